/* hw/rtl/vkv_pkg.sv */
// ----------------------------------------------------------------------------
// vkv_pkg
// Shared types and constants of the varint key/value stream decoder.
// ----------------------------------------------------------------------------
package vkv_pkg;

   localparam int LengthBitsDefault = 25;
   localparam int LimitWidth        = 25;
   localparam int MidQueueDepth     = 4;
   localparam int OutQueueDepth     = 4;

   localparam logic [LimitWidth-1:0] LimitReset = 25'd16777216;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_ENTRY = 2'd2;
   localparam logic [1:0] KIND_FINAL = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_TRUNC = 2'd1;
   localparam logic [1:0] STATUS_LONG  = 2'd2;
   localparam logic [1:0] STATUS_LIMIT = 2'd3;

   localparam logic [7:0] CHAR_C   = 8'h43;
   localparam logic [7:0] CHAR_T   = 8'h54;
   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [7:0] CHAR_ONE = 8'h31;
   localparam logic [7:0] CHAR_TWO = 8'h32;

   localparam logic [4:0] HDR2_LEN = 5'd16;
   localparam logic [4:0] HDR1_LEN = 5'd12;

   typedef struct packed {
      logic [7:0] data;
      logic       parse;
      logic       fin;
      logic       hdr_trunc;
      logic       item_end;
   } op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic [1:0] status;
      logic       run_last;
   } res_type;

endpackage

/* hw/rtl/varint_key_value_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// varint_key_value_stream_decoder_core
// Throughput: 1 byte per cycle while full is low; full is high during a header replay or with the mid queue full.
// During a header replay the held bytes and then the current byte are issued with push stalled (full high).
// A record-closing value byte or a last byte stays in the back end while its extra results are issued.
// Reset is synchronous: queues drain, state clears, limit returns to 16777216.
// ----------------------------------------------------------------------------
module varint_key_value_stream_decoder_core
   import vkv_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault,
   parameter int MID_DEPTH   = MidQueueDepth,
   parameter int OUT_DEPTH   = OutQueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  push,
   output logic                  full,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_payload_byte,
   output logic [1:0]            rsp_status,
   output logic                  rsp_run_last,
   output logic                  empty,
   input  logic                  pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LimitWidth-1:0] csr_max_field_length
);

   logic [LimitWidth-1:0] max_len_ff;

   op_type  fr_op;
   logic    fr_push;
   logic    mid_full;
   logic    mid_empty;
   op_type  mid_op;
   logic    bk_pop;
   res_type bk_res;
   logic    bk_push;
   logic    out_full;
   res_type out_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LimitReset;
      end else if (csr_valid) begin
         max_len_ff <= csr_max_field_length;
      end
   end

   vkv_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_data (req_data_byte),
      .in_last (req_last_byte),
      .push    (push),
      .full    (full),
      .op_push (fr_push),
      .op      (fr_op),
      .op_full (mid_full)
   );

   vkv_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fr_push),
      .wr_data (fr_op),
      .full    (mid_full),
      .rd_en   (bk_pop),
      .rd_data (mid_op),
      .empty   (mid_empty)
   );

   vkv_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .max_len  (max_len_ff),
      .op_valid (~mid_empty),
      .op       (mid_op),
      .op_pop   (bk_pop),
      .res_push (bk_push),
      .res      (bk_res),
      .res_full (out_full)
   );

   vkv_fifo #(
      .WIDTH ($bits(res_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bk_push),
      .wr_data (bk_res),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (out_res),
      .empty   (empty)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_payload_byte = out_res.payload;
   assign rsp_status       = out_res.status;
   assign rsp_run_last     = out_res.run_last;

endmodule

/* hw/rtl/vkv_fifo.sv */
// ----------------------------------------------------------------------------
// vkv_fifo
// Small register queue with push/pop handshake and occupancy count.
// ----------------------------------------------------------------------------
module vkv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hw/rtl/vkv_front.sv */
// ----------------------------------------------------------------------------
// vkv_front
// Header check, header skip and replay of held bytes; issues parse operations.
// ----------------------------------------------------------------------------
module vkv_front
   import vkv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] in_data,
   input  logic       in_last,
   input  logic       push,
   output logic       full,
   output logic       op_push,
   output op_type     op,
   input  logic       op_full
);

   localparam logic [1:0] FS_HDR   = 2'd0;
   localparam logic [1:0] FS_SKIP2 = 2'd1;
   localparam logic [1:0] FS_SKIP1 = 2'd2;
   localparam logic [1:0] FS_PARSE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [4:0] count_ff, count_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic       rp_active_ff, rp_active_in;
   logic [1:0] rp_idx_ff, rp_idx_in;
   logic [1:0] rp_num_ff, rp_num_in;
   logic [7:0] rp_data_ff, rp_data_in;
   logic       rp_last_ff, rp_last_in;
   logic       accept;
   logic       cts;
   logic       skip_done;

   assign full   = rp_active_ff | op_full;
   assign accept = push & ~full;
   assign cts    = (held_ff[0] == CHAR_C) && (held_ff[1] == CHAR_T) && (held_ff[2] == CHAR_S);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      held_in      = held_ff;
      rp_active_in = rp_active_ff;
      rp_idx_in    = rp_idx_ff;
      rp_num_in    = rp_num_ff;
      rp_data_in   = rp_data_ff;
      rp_last_in   = rp_last_ff;
      op_push      = 1'b0;
      op           = '0;
      skip_done    = 1'b0;
      if (rp_active_ff) begin
         if (!op_full) begin
            op_push    = 1'b1;
            op.parse   = 1'b1;
            if (rp_idx_ff == rp_num_ff) begin
               op.data      = rp_data_ff;
               op.fin       = rp_last_ff;
               op.item_end  = 1'b1;
               rp_active_in = 1'b0;
            end else begin
               op.data   = held_ff[rp_idx_ff];
               rp_idx_in = rp_idx_ff + 2'd1;
            end
         end
      end else if (accept) begin
         unique case (state_ff) inside
            FS_HDR: begin
               if (count_ff < 5'd3) begin
                  held_in[count_ff[1:0]] = in_data;
                  count_in = count_ff + 5'd1;
                  if (in_last) begin
                     rp_active_in = 1'b1;
                     rp_idx_in    = 2'd0;
                     rp_num_in    = count_ff[1:0];
                     rp_data_in   = in_data;
                     rp_last_in   = 1'b1;
                  end
               end else begin
                  count_in = 5'd4;
                  if (cts && (in_data == CHAR_TWO || in_data == CHAR_ONE)) begin
                     state_in = (in_data == CHAR_TWO) ? FS_SKIP2 : FS_SKIP1;
                     if (in_last) begin
                        op_push      = 1'b1;
                        op.fin       = 1'b1;
                        op.hdr_trunc = 1'b1;
                        op.item_end  = 1'b1;
                     end
                  end else begin
                     state_in     = FS_PARSE;
                     rp_active_in = 1'b1;
                     rp_idx_in    = 2'd0;
                     rp_num_in    = 2'd3;
                     rp_data_in   = in_data;
                     rp_last_in   = in_last;
                  end
               end
            end
            FS_SKIP2, FS_SKIP1: begin
               count_in  = count_ff + 5'd1;
               skip_done = (count_in >= ((state_ff == FS_SKIP2) ? HDR2_LEN : HDR1_LEN));
               if (skip_done) begin
                  state_in = FS_PARSE;
               end
               if (in_last) begin
                  op_push      = 1'b1;
                  op.fin       = 1'b1;
                  op.hdr_trunc = ~skip_done;
                  op.item_end  = 1'b1;
               end
            end
            FS_PARSE: begin
               op_push     = 1'b1;
               op.data     = in_data;
               op.parse    = 1'b1;
               op.fin      = in_last;
               op.item_end = 1'b1;
            end
            default: ;
         endcase
         if (in_last) begin
            state_in = FS_HDR;
            count_in = 5'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_HDR;
         count_ff     <= 5'd0;
         rp_active_ff <= 1'b0;
         rp_idx_ff    <= 2'd0;
         rp_num_ff    <= 2'd0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_active_ff <= rp_active_in;
         rp_idx_ff    <= rp_idx_in;
         rp_num_ff    <= rp_num_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff    <= held_in;
      rp_data_ff <= rp_data_in;
      rp_last_ff <= rp_last_in;
   end

endmodule

/* hw/rtl/vkv_back.sv */
// ----------------------------------------------------------------------------
// vkv_back
// Record parser: LEB128 lengths, key and value bytes, entry marks and status.
// ----------------------------------------------------------------------------
module vkv_back
   import vkv_pkg::*;
#(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LimitWidth-1:0] max_len,
   input  logic                  op_valid,
   input  op_type                op,
   output logic                  op_pop,
   output logic                  res_push,
   output res_type               res,
   input  logic                  res_full
);

   localparam int CMP_W = (LENGTH_BITS > LimitWidth) ? LENGTH_BITS : LimitWidth;

   localparam logic [2:0] PH_KLEN = 3'd0;
   localparam logic [2:0] PH_KEY  = 3'd1;
   localparam logic [2:0] PH_VLEN = 3'd2;
   localparam logic [2:0] PH_VAL  = 3'd3;
   localparam logic [2:0] PH_ERR  = 3'd4;

   localparam logic [1:0] SUB_MAIN  = 2'd0;
   localparam logic [1:0] SUB_ENTRY = 2'd1;
   localparam logic [1:0] SUB_FINAL = 2'd2;

   logic [2:0]             phase_ff, phase_in;
   logic [1:0]             sub_ff, sub_in;
   logic [LENGTH_BITS-1:0] value_ff, value_in;
   logic                   ovf_ff, ovf_in;
   logic [3:0]             shift_ff, shift_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [1:0]             err_ff, err_in;
   res_type                pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic                   pend_closed_ff, pend_closed_in;

   logic                   go;
   logic                   done;
   logic                   end_item;
   logic                   need_entry;
   logic                   nr_valid;
   res_type                nr;
   logic [6:0]             shift7;
   logic [63:0]            grp;
   logic [63:0]            grp_hi;
   logic [LENGTH_BITS-1:0] vnew;
   logic                   onew;
   logic                   over;

   assign go     = op_valid & ~res_full;
   assign shift7 = {shift_ff, 3'b000} - {3'b000, shift_ff};
   assign grp    = {57'd0, op.data[6:0]} << shift7;
   assign grp_hi = grp >> LENGTH_BITS;
   assign vnew   = value_ff | grp[LENGTH_BITS-1:0];
   assign onew   = ovf_ff | (|grp_hi);
   assign over   = CMP_W'(vnew) > CMP_W'(max_len);

   always_comb begin
      phase_in   = phase_ff;
      sub_in     = sub_ff;
      value_in   = value_ff;
      ovf_in     = ovf_ff;
      shift_in   = shift_ff;
      remain_in  = remain_ff;
      err_in     = err_ff;
      done       = 1'b0;
      need_entry = 1'b0;
      nr_valid   = 1'b0;
      nr         = '0;
      if (go) begin
         unique case (sub_ff)
            SUB_MAIN: begin
               if (op.parse) begin
                  case (phase_ff) inside
                     PH_KLEN, PH_VLEN: begin
                        value_in = vnew;
                        ovf_in   = onew;
                        if (!op.data[7]) begin
                           value_in = '0;
                           ovf_in   = 1'b0;
                           shift_in = 4'd0;
                           if (onew || over) begin
                              err_in   = (err_ff == STATUS_OK) ? STATUS_LIMIT : err_ff;
                              phase_in = PH_ERR;
                           end else if (vnew == '0) begin
                              if (phase_ff == PH_KLEN) begin
                                 phase_in = PH_VLEN;
                              end else begin
                                 nr_valid = 1'b1;
                                 nr.kind  = KIND_ENTRY;
                                 phase_in = PH_KLEN;
                              end
                           end else begin
                              remain_in = vnew;
                              phase_in  = (phase_ff == PH_KLEN) ? PH_KEY : PH_VAL;
                           end
                        end else if (shift_ff >= 4'd9) begin
                           value_in = '0;
                           ovf_in   = 1'b0;
                           shift_in = 4'd0;
                           err_in   = (err_ff == STATUS_OK) ? STATUS_LONG : err_ff;
                           phase_in = PH_ERR;
                        end else begin
                           shift_in = shift_ff + 4'd1;
                        end
                     end
                     PH_KEY: begin
                        nr_valid   = 1'b1;
                        nr.kind    = KIND_KEY;
                        nr.payload = op.data;
                        remain_in  = remain_ff - LENGTH_BITS'(1);
                        if (remain_ff == LENGTH_BITS'(1)) begin
                           phase_in = PH_VLEN;
                        end
                     end
                     PH_VAL: begin
                        nr_valid   = 1'b1;
                        nr.kind    = KIND_VALUE;
                        nr.payload = op.data;
                        remain_in  = remain_ff - LENGTH_BITS'(1);
                        if (remain_ff == LENGTH_BITS'(1)) begin
                           phase_in   = PH_KLEN;
                           need_entry = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               if (need_entry) begin
                  sub_in = SUB_ENTRY;
               end else if (op.fin) begin
                  sub_in = SUB_FINAL;
               end else begin
                  done = 1'b1;
               end
            end
            SUB_ENTRY: begin
               nr_valid = 1'b1;
               nr.kind  = KIND_ENTRY;
               if (op.fin) begin
                  sub_in = SUB_FINAL;
               end else begin
                  done = 1'b1;
               end
            end
            SUB_FINAL: begin
               nr_valid = 1'b1;
               nr.kind  = KIND_FINAL;
               if (err_ff != STATUS_OK) begin
                  nr.status = err_ff;
               end else if (!op.hdr_trunc && phase_ff == PH_KLEN && shift_ff == 4'd0) begin
                  nr.status = STATUS_OK;
               end else begin
                  nr.status = STATUS_TRUNC;
               end
               phase_in  = PH_KLEN;
               value_in  = '0;
               ovf_in    = 1'b0;
               shift_in  = 4'd0;
               remain_in = '0;
               err_in    = STATUS_OK;
               done      = 1'b1;
            end
            default: begin
               sub_in = SUB_MAIN;
            end
         endcase
         if (done) begin
            sub_in = SUB_MAIN;
         end
      end
   end

   assign op_pop   = go & done;
   assign end_item = go & done & op.item_end;

   // hold the newest result until it is known whether it closes its transaction
   always_comb begin
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      pend_closed_in = pend_closed_ff;
      res_push       = 1'b0;
      res            = pend_ff;
      if (!res_full) begin
         if (pend_valid_ff && pend_closed_ff) begin
            res_push       = 1'b1;
            res.run_last   = 1'b1;
            pend_valid_in  = 1'b0;
         end
         if (nr_valid) begin
            if (pend_valid_ff && !pend_closed_ff) begin
               res_push     = 1'b1;
               res.run_last = 1'b0;
            end
            pend_in        = nr;
            pend_valid_in  = 1'b1;
            pend_closed_in = end_item;
         end else if (end_item && pend_valid_ff && !pend_closed_ff) begin
            res_push      = 1'b1;
            res.run_last  = 1'b1;
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_KLEN;
         sub_ff         <= SUB_MAIN;
         value_ff       <= '0;
         ovf_ff         <= 1'b0;
         shift_ff       <= 4'd0;
         remain_ff      <= '0;
         err_ff         <= STATUS_OK;
         pend_valid_ff  <= 1'b0;
         pend_closed_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         sub_ff         <= sub_in;
         value_ff       <= value_in;
         ovf_ff         <= ovf_in;
         shift_ff       <= shift_in;
         remain_ff      <= remain_in;
         err_ff         <= err_in;
         pend_valid_ff  <= pend_valid_in;
         pend_closed_ff <= pend_closed_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

/* tb/vkv_record_checker.sv */
// ----------------------------------------------------------------------------
// vkv_record_checker
// Watches the byte, result and limit channels of the key/value stream
// decoder, predicts the result transactions of each accepted byte and checks
// every popped result against the oldest prediction.
// ----------------------------------------------------------------------------
module vkv_record_checker
   import vkv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  push,
   input  logic                  full,
   input  logic [1:0]            rsp_kind,
   input  logic [7:0]            rsp_payload_byte,
   input  logic [1:0]            rsp_status,
   input  logic                  rsp_run_last,
   input  logic                  empty,
   input  logic                  pop,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [LimitWidth-1:0] csr_max_field_length,
   output int                    mismatches,
   output int                    pending_results,
   output int                    results_checked,
   output int                    blobs_closed,
   output logic [3:0]            status_seen
);

   localparam int LengthBits  = LengthBitsDefault;
   localparam int MaxResults  = 9;
   localparam int ReportLimit = 20;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP_LONG,
      PH_SKIP_SHORT,
      PH_KEY_LEN,
      PH_KEY_DATA,
      PH_VAL_LEN,
      PH_VAL_DATA,
      PH_FAULT
   } parse_phase_type;

   parse_phase_type phase_q;
   logic [7:0]      held_q [3];
   logic [4:0]      hdr_count;
   logic [24:0]     len_acc;
   logic            len_ovf;
   logic [3:0]      len_groups;
   logic [24:0]     bytes_left;
   logic [1:0]      err_code;
   logic [24:0]     field_limit;

   res_type         step_res [$];
   res_type         record_q [$];
   res_type         got_res;
   res_type         want_res;

   int              fail_total    = 0;
   int              checked_total = 0;
   int              closed_total  = 0;
   logic [3:0]      seen_mask     = 4'b0000;

   function automatic void emit_result(logic [1:0] kind, logic [7:0] payload,
                                       logic [1:0] status);
      res_type r;
      if (step_res.size() < MaxResults) begin
         r.kind     = kind;
         r.payload  = payload;
         r.status   = status;
         r.run_last = 1'b0;
         step_res.push_back(r);
      end
   endfunction

   function automatic void clear_length();
      len_acc    = '0;
      len_ovf    = 1'b0;
      len_groups = '0;
   endfunction

   function automatic void clear_parse_state();
      phase_q    = PH_HEADER;
      held_q[0]  = '0;
      held_q[1]  = '0;
      held_q[2]  = '0;
      hdr_count  = '0;
      bytes_left = '0;
      err_code   = STATUS_OK;
      clear_length();
   endfunction

   function automatic void raise_error(logic [1:0] code);
      if (err_code == STATUS_OK) err_code = code;
      phase_q = PH_FAULT;
   endfunction

   function automatic void close_length();
      logic [24:0]     len;
      logic            bad;
      parse_phase_type ph;
      len = len_acc;
      bad = len_ovf || (len > field_limit);
      ph  = phase_q;
      clear_length();
      if (bad) begin
         raise_error(STATUS_LIMIT);
      end else if (len == '0) begin
         if (ph == PH_KEY_LEN) begin
            phase_q = PH_VAL_LEN;
         end else begin
            emit_result(KIND_ENTRY, 8'h00, STATUS_OK);
            phase_q = PH_KEY_LEN;
         end
      end else begin
         bytes_left = len;
         phase_q    = (ph == PH_KEY_LEN) ? PH_KEY_DATA : PH_VAL_DATA;
      end
   endfunction

   function automatic void parse_record_byte(logic [7:0] b);
      int pos;
      int k;
      case (phase_q)
         PH_KEY_LEN, PH_VAL_LEN: begin
            for (k = 0; k < 7; k++) begin
               pos = int'(len_groups) * 7 + k;
               if (b[k] && pos <= 63) begin
                  if (pos >= LengthBits) len_ovf = 1'b1;
                  else len_acc[pos] = 1'b1;
               end
            end
            if (!b[7]) begin
               close_length();
            end else if (len_groups >= 4'd9) begin
               clear_length();
               raise_error(STATUS_LONG);
            end else begin
               len_groups = len_groups + 4'd1;
            end
         end
         PH_KEY_DATA: begin
            emit_result(KIND_KEY, b, STATUS_OK);
            bytes_left = bytes_left - 25'd1;
            if (bytes_left == '0) phase_q = PH_VAL_LEN;
         end
         PH_VAL_DATA: begin
            emit_result(KIND_VALUE, b, STATUS_OK);
            bytes_left = bytes_left - 25'd1;
            if (bytes_left == '0) begin
               emit_result(KIND_ENTRY, 8'h00, STATUS_OK);
               phase_q = PH_KEY_LEN;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void replay_held(int count, logic [7:0] cur);
      int i;
      phase_q = PH_KEY_LEN;
      for (i = 0; i < count && i < 3; i++) parse_record_byte(held_q[i]);
      parse_record_byte(cur);
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic is_last);
      logic       cts;
      logic [1:0] fin_status;
      res_type    tail;
      step_res.delete();
      case (phase_q)
         PH_HEADER: begin
            if (hdr_count < 5'd3) begin
               held_q[hdr_count[1:0]] = b;
               hdr_count = hdr_count + 5'd1;
               if (is_last) replay_held(int'(hdr_count) - 1, b);
            end else begin
               cts = held_q[0] == CHAR_C && held_q[1] == CHAR_T && held_q[2] == CHAR_S;
               hdr_count = 5'd4;
               if (cts && b == CHAR_TWO) phase_q = PH_SKIP_LONG;
               else if (cts && b == CHAR_ONE) phase_q = PH_SKIP_SHORT;
               else replay_held(3, b);
            end
         end
         PH_SKIP_LONG, PH_SKIP_SHORT: begin
            hdr_count = hdr_count + 5'd1;
            if (hdr_count >= ((phase_q == PH_SKIP_LONG) ? HDR2_LEN : HDR1_LEN))
               phase_q = PH_KEY_LEN;
         end
         default: parse_record_byte(b);
      endcase
      if (is_last) begin
         if (err_code != STATUS_OK) fin_status = err_code;
         else if (phase_q == PH_KEY_LEN && len_groups == '0) fin_status = STATUS_OK;
         else fin_status = STATUS_TRUNC;
         emit_result(KIND_FINAL, 8'h00, fin_status);
         clear_parse_state();
      end
      if (step_res.size() > 0) begin
         tail = step_res.pop_back();
         tail.run_last = 1'b1;
         step_res.push_back(tail);
      end
      foreach (step_res[i]) record_q.push_back(step_res[i]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_parse_state();
         field_limit = LimitReset;
         record_q.delete();
      end else begin
         if (csr_valid && csr_ready) field_limit = csr_max_field_length;
         if (pop && !empty) begin
            got_res.kind     = rsp_kind;
            got_res.payload  = rsp_payload_byte;
            got_res.status   = rsp_status;
            got_res.run_last = rsp_run_last;
            checked_total++;
            if (record_q.size() == 0) begin
               fail_total++;
               if (fail_total <= ReportLimit)
                  $display("%0t: unexpected result, expected none, got kind=%0d payload=%02h",
                           $time, got_res.kind, got_res.payload,
                           " status=%0d last=%0b", got_res.status, got_res.run_last);
            end else begin
               want_res = record_q.pop_front();
               if (got_res !== want_res) begin
                  fail_total++;
                  if (fail_total <= ReportLimit)
                     $display("%0t: result mismatch, expected kind=%0d payload=%02h",
                              $time, want_res.kind, want_res.payload,
                              " status=%0d last=%0b, got kind=%0d payload=%02h",
                              want_res.status, want_res.run_last, got_res.kind,
                              got_res.payload, " status=%0d last=%0b",
                              got_res.status, got_res.run_last);
               end
               if (want_res.kind == KIND_FINAL) begin
                  closed_total++;
                  seen_mask[want_res.status] = 1'b1;
               end
            end
         end
         if (push && !full) decode_byte(req_data_byte, req_last_byte);
      end
      mismatches      <= fail_total;
      pending_results <= record_q.size();
      results_checked <= checked_total;
      blobs_closed    <= closed_total;
      status_seen     <= seen_mask;
   end

endmodule

/* tb/tb_varint_key_value_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// tb_varint_key_value_stream_decoder_core
// Feeds snapshot blobs byte by byte into the key/value stream decoder: a
// directed set of headers, short blobs, varint corner cases and limit hits,
// then random well-formed, truncated and noisy blobs under several field
// length limits, with bursty input, a stalling consumer and long hold-offs.
// ----------------------------------------------------------------------------
module tb_varint_key_value_stream_decoder_core
   import vkv_pkg::*;
();

   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 16;
   localparam int HoldCycles  = 150;
   localparam int PhaseBytes  = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic [7:0]            req_data_byte;
   logic                  req_last_byte;
   logic                  push;
   logic                  full;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_payload_byte;
   logic [1:0]            rsp_status;
   logic                  rsp_run_last;
   logic                  empty;
   logic                  pop;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LimitWidth-1:0] csr_max_field_length;

   int                    mismatches;
   int                    pending_results;
   int                    results_checked;
   int                    blobs_closed;
   logic [3:0]            status_seen;

   logic [7:0]            blob_q [$];
   logic [24:0]           limit_now     = LimitReset;
   int                    burst_left    = 0;
   int                    bytes_sent    = 0;
   int                    blobs_sent    = 0;
   int                    limit_writes  = 0;
   int                    hold_requests = 0;
   int                    holds_done    = 0;
   int                    cycle_count   = 0;

   varint_key_value_stream_decoder_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .push                 (push),
      .full                 (full),
      .rsp_kind             (rsp_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_status           (rsp_status),
      .rsp_run_last         (rsp_run_last),
      .empty                (empty),
      .pop                  (pop),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_field_length (csr_max_field_length)
   );

   vkv_record_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .push                 (push),
      .full                 (full),
      .rsp_kind             (rsp_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_status           (rsp_status),
      .rsp_run_last         (rsp_run_last),
      .empty                (empty),
      .pop                  (pop),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_field_length (csr_max_field_length),
      .mismatches           (mismatches),
      .pending_results      (pending_results),
      .results_checked      (results_checked),
      .blobs_closed         (blobs_closed),
      .status_seen          (status_seen)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t: cycle limit reached with %0d results outstanding",
                  $time, pending_results);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int mode;
      int span;
      int beat;
      mode = 0;
      span = 0;
      beat = 0;
      pop <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            pop <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 40);
         end
         span--;
         beat++;
         case (mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (beat % 5) < 3;
         endcase
         @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_data_byte <= value;
      req_last_byte <= is_last;
      push          <= 1'b1;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   task automatic send_blob();
      for (int i = 0; i < blob_q.size(); i++) send_byte(blob_q[i], i == blob_q.size() - 1);
      blobs_sent++;
      blob_q.delete();
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(input logic [24:0] value);
      wait_idle();
      csr_max_field_length <= value;
      csr_valid            <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_now  = value;
      burst_left = 0;
      limit_writes++;
   endtask

   task automatic put_random(input int count);
      repeat (count) blob_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic put_header(input logic [7:0] tag, input int body);
      blob_q.push_back(CHAR_C);
      blob_q.push_back(CHAR_T);
      blob_q.push_back(CHAR_S);
      blob_q.push_back(tag);
      put_random(body);
   endtask

   task automatic put_varint(input logic [24:0] value, input int pad);
      logic [24:0] rest;
      rest = value;
      while (rest >= 25'd128) begin
         blob_q.push_back({1'b1, rest[6:0]});
         rest = rest >> 7;
      end
      if (pad > 0) begin
         blob_q.push_back({1'b1, rest[6:0]});
         repeat (pad - 1) blob_q.push_back(8'h80);
         blob_q.push_back(8'h00);
      end else begin
         blob_q.push_back({1'b0, rest[6:0]});
      end
   endtask

   function automatic int pick_length();
      if ($urandom_range(0, 29) == 0) return int'(limit_now) + 1;
      if (limit_now < 25'd8) return $urandom_range(0, int'(limit_now) + 2);
      return $urandom_range(0, 5);
   endfunction

   function automatic int pick_pad();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
   endfunction

   task automatic put_field();
      int len;
      len = pick_length();
      put_varint(25'(len), pick_pad());
      if (len > 8) put_random(3);
      else put_random(len);
   endtask

   task automatic build_random_blob();
      int style;
      int hdr;
      int nrec;
      int cut;
      style = $urandom_range(0, 19);
      if (style < 15) begin
         hdr = $urandom_range(0, 4);
         if (hdr == 0) put_header(CHAR_ONE, 8);
         else if (hdr == 1) put_header(CHAR_TWO, 12);
         nrec = $urandom_range((hdr <= 1) ? 0 : 1, 4);
         repeat (nrec) begin
            put_field();
            put_field();
         end
         if (style >= 12 && blob_q.size() > 1) begin
            cut = $urandom_range(1, blob_q.size() - 1);
            while (blob_q.size() > cut) void'(blob_q.pop_back());
         end
      end else if (style < 17) begin
         if ($urandom_range(0, 1) == 1) put_header(8'($urandom_range(8'h30, 8'h33)), 0);
         put_random($urandom_range(1, 12));
      end else if (style < 19) begin
         repeat ($urandom_range(8, 11)) blob_q.push_back({1'b1, 7'($urandom_range(0, 127))});
         put_random($urandom_range(1, 4));
      end else begin
         put_header(($urandom_range(0, 1) == 1) ? CHAR_ONE : CHAR_TWO, $urandom_range(0, 11));
      end
      if (blob_q.size() == 0) put_random(1);
   endtask

   task automatic run_random_phase(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         build_random_blob();
         send_blob();
      end
   endtask

   task automatic run_directed();
      put_header(CHAR_TWO, 12);
      send_blob();
      put_header(CHAR_TWO, 12);
      blob_q.push_back(8'h02);
      blob_q.push_back(8'h00);
      blob_q.push_back(8'hFF);
      blob_q.push_back(8'h01);
      blob_q.push_back(8'h80);
      send_blob();
      put_header(CHAR_ONE, 8);
      blob_q.push_back(8'h00);
      blob_q.push_back(8'h02);
      blob_q.push_back(8'h7F);
      blob_q.push_back(8'h80);
      send_blob();
      put_header(CHAR_ONE, 5);
      send_blob();
      put_header(CHAR_TWO, 0);
      send_blob();
      blob_q = '{8'h00};
      send_blob();
      blob_q = '{8'h00, 8'h00};
      send_blob();
      blob_q = '{8'h01, CHAR_C, 8'h00};
      send_blob();
      blob_q = '{CHAR_C, CHAR_T, CHAR_S, 8'h33};
      send_blob();
      blob_q = '{8'h01, 8'h11, 8'h01, 8'h22, 8'h00, 8'h00};
      send_blob();
      // continuation bit still set on the tenth length byte
      repeat (10) blob_q.push_back(8'h80);
      blob_q.push_back(8'h05);
      blob_q.push_back(8'h06);
      send_blob();
      // payload bits past bit 63 drop out of the length
      blob_q.push_back(8'h82);
      repeat (8) blob_q.push_back(8'h80);
      blob_q.push_back(8'h7E);
      blob_q.push_back(8'hA5);
      blob_q.push_back(8'h5A);
      blob_q.push_back(8'h00);
      send_blob();
      repeat (9) blob_q.push_back(8'h80);
      blob_q.push_back(8'h01);
      blob_q.push_back(8'h00);
      send_blob();
      blob_q = '{8'h81, 8'h80, 8'h80, 8'h08, 8'h55};
      send_blob();
      blob_q = '{8'h80, 8'h80, 8'h80, 8'h08, 8'hDE, 8'hAD};
      send_blob();
      blob_q = '{8'h80, 8'h80, 8'h80, 8'h40, 8'h00};
      send_blob();
      blob_q = '{8'h00, 8'h00, 8'h85};
      send_blob();
      blob_q = '{8'h01, 8'h41};
      send_blob();
      blob_q = '{8'h03, 8'h41};
      send_blob();
   endtask

   initial begin
      reset                <= 1'b1;
      push                 <= 1'b0;
      req_data_byte        <= 8'h00;
      req_last_byte        <= 1'b0;
      csr_valid            <= 1'b0;
      csr_max_field_length <= LimitReset;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      write_limit(25'd0);
      blob_q = '{8'h00, 8'h00};
      send_blob();
      blob_q = '{8'h01, 8'h41, 8'h00};
      send_blob();
      blob_q = '{8'h00, 8'h01, 8'h77};
      send_blob();
      run_random_phase(PhaseBytes / 2);

      write_limit(LimitReset);
      hold_requests++;
      run_random_phase(PhaseBytes);

      write_limit(25'($urandom_range(1, 7)));
      run_random_phase(PhaseBytes);

      write_limit(25'($urandom_range(8, 16777216)));
      hold_requests++;
      run_random_phase(PhaseBytes);

      wait_idle();
      $display("Covered %0d bytes in %0d blobs over %0d limit writes; %0d results checked.",
               bytes_sent, blobs_sent, limit_writes, results_checked);
      $display("Blobs closed: %0d, final status codes seen (bit per code): %b",
               blobs_closed, status_seen);
      if (mismatches == 0 && pending_results == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
